/* rtl/ghpid_pkg.sv */
// ----------------------------------------------------------------------------
// ghpid_pkg
// Shared types and constants for the gyro heading PID controller.
// ----------------------------------------------------------------------------
package ghpid_pkg;

  localparam int MUL_STEPS = 32;
  localparam int DIV_STEPS = 56;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  localparam logic [1:0] KIND_CAL   = 2'd0;
  localparam logic [1:0] KIND_ANGLE = 2'd1;
  localparam logic [1:0] KIND_PID   = 2'd2;

  localparam logic [2:0] REG_LSB_PER_DPS = 3'd0;
  localparam logic [2:0] REG_CALIB_COUNT = 3'd1;
  localparam logic [2:0] REG_GAIN_P      = 3'd2;
  localparam logic [2:0] REG_GAIN_I      = 3'd3;
  localparam logic [2:0] REG_GAIN_D      = 3'd4;
  localparam logic [2:0] REG_DRIVE_MIN   = 3'd5;
  localparam logic [2:0] REG_DRIVE_MAX   = 3'd6;

  localparam logic [19:0] US_PER_S = 20'd1000000;

  typedef struct packed {
    logic go;
    logic op;
  } ser_cmd_t;

  typedef struct packed {
    logic        done;
    logic [79:0] res;
  } ser_rsp_t;

endpackage

/* rtl/ghpid_serial.sv */
// ----------------------------------------------------------------------------
// ghpid_serial
// Bit-serial unsigned multiplier (48 x 32, one multiplier bit per cycle) and
// restoring divider (56 / 20, one quotient bit per cycle).
// ----------------------------------------------------------------------------
module ghpid_serial (
  input  logic                clk,
  input  logic                rst,
  input  ghpid_pkg::ser_cmd_t cmd,
  input  logic [55:0]         a,
  input  logic [31:0]         b,
  output ghpid_pkg::ser_rsp_t rsp
);
  import ghpid_pkg::*;

  logic        busy;
  logic        op_r;
  logic [5:0]  cnt;
  logic [79:0] acc;
  logic [47:0] opnd;
  logic [19:0] rem;
  logic        done;

  logic [48:0] upper;
  logic [20:0] trial;
  logic [20:0] diff;

  always_comb begin
    upper = {1'b0, acc[79:32]} + (acc[0] ? {1'b0, opnd} : 49'd0);
    trial = {rem, acc[55]};
    diff  = trial - {1'b0, opnd[19:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.go) begin
        busy <= 1'b1;
        op_r <= cmd.op;
        cnt  <= (cmd.op == OP_DIV) ? 6'(DIV_STEPS - 1) : 6'(MUL_STEPS - 1);
        acc  <= (cmd.op == OP_DIV) ? {24'd0, a} : {48'd0, b};
        opnd <= (cmd.op == OP_DIV) ? {28'd0, b[19:0]} : a[47:0];
        rem  <= '0;
      end else if (busy) begin
        if (op_r == OP_MUL) begin
          acc <= {upper, acc[31:1]};
        end else begin
          if (!diff[20]) begin
            rem <= diff[19:0];
          end else begin
            rem <= trial[19:0];
          end
          acc[55:0] <= {acc[54:0], ~diff[20]};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.res  = acc;

endmodule

/* rtl/gyro_heading_pid_controller_unit.sv */
// ----------------------------------------------------------------------------
// gyro_heading_pid_controller_unit
// Gyro calibration, heading integration and clamped PID drive.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one item: kind, raw_rate,
// time_step_us, target_angle. Each item gives exactly one result on the
// output channel (out_valid/out_stall): heading, rate_dps, drive, calibrated.
// One item is worked at a time; in_stall is low only while the block is idle.
// All multiplies and divides run through one shared bit-serial unit. Work per
// item, from transfer to result register:
//   calibration sample: a divide on completion of the count, else none
//   angle sample: divide, multiply, divide
//   PID request: multiply and divide for the integral, multiply and divide
//   for the derivative when dt != 0, then three gain multiplies
//   unknown kind: none
// The next item can transfer at the edge after the result is loaded, even
// while out_stall holds it. If the output register is still full when the next
// result is ready, the block waits. Reset restores register defaults and
// clears the kept state.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
// ----------------------------------------------------------------------------
module gyro_heading_pid_controller_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [15:0] raw_rate,
  input  logic [19:0]        time_step_us,
  input  logic signed [31:0] target_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] heading,
  output logic signed [31:0] rate_dps,
  output logic [15:0]        drive,
  output logic               calibrated
);
  import ghpid_pkg::*;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_PREP     = 4'd1;
  localparam logic [3:0] ST_CAL_DIV  = 4'd2;
  localparam logic [3:0] ST_RATE_DIV = 4'd3;
  localparam logic [3:0] ST_HEAD_MUL = 4'd4;
  localparam logic [3:0] ST_HEAD_DIV = 4'd5;
  localparam logic [3:0] ST_I_MUL    = 4'd6;
  localparam logic [3:0] ST_I_DIV    = 4'd7;
  localparam logic [3:0] ST_D_MUL    = 4'd8;
  localparam logic [3:0] ST_D_DIV    = 4'd9;
  localparam logic [3:0] ST_P_GAIN   = 4'd10;
  localparam logic [3:0] ST_I_GAIN   = 4'd11;
  localparam logic [3:0] ST_D_GAIN   = 4'd12;
  localparam logic [3:0] ST_DRIVE    = 4'd13;
  localparam logic [3:0] ST_DONE     = 4'd14;
  localparam logic [3:0] ST_HEAD_SUM = 4'd15;

  localparam logic signed [33:0] SAT32_MAX = 34'sh0_7FFF_FFFF;
  localparam logic signed [33:0] SAT32_MIN = -34'sh0_8000_0000;
  localparam logic signed [48:0] SAT48_MAX = 49'sh0_7FFF_FFFF_FFFF;
  localparam logic signed [48:0] SAT48_MIN = -49'sh0_8000_0000_0000;
  localparam logic [63:0]        TERM_LIM  = 64'h0004_0000_0000_0000;

  function automatic logic [31:0] err_mag_r(input logic signed [31:0] e);
    err_mag_r = e[31] ? 32'(-e) : 32'(e);
  endfunction

  // configuration
  logic [15:0]        lsb_per_dps;
  logic [15:0]        calib_count;
  logic signed [31:0] gain_p;
  logic signed [31:0] gain_i;
  logic signed [31:0] gain_d;
  logic [15:0]        drive_min;
  logic [15:0]        drive_max;

  // kept state
  logic signed [31:0] heading_acc;
  logic signed [39:0] rate_offset;
  logic signed [39:0] calib_sum;
  logic [16:0]        calib_seen;
  logic signed [47:0] error_integral;
  logic signed [31:0] last_error;
  logic               offset_ready;

  // item and work registers
  logic [3:0]         state;
  logic [1:0]         kind_r;
  logic signed [15:0] raw_r;
  logic [19:0]        dt_r;
  logic signed [31:0] tgt_r;
  logic signed [31:0] err_r;
  logic signed [47:0] deriv_r;
  logic signed [31:0] rate_r;
  logic signed [52:0] total_r;
  logic [15:0]        drive_r;
  logic               neg_r;

  ser_cmd_t    u_cmd;
  logic [55:0] u_a;
  logic [31:0] u_b;
  ser_rsp_t    u_rsp;

  ghpid_serial u_serial (
    .clk (clk),
    .rst (rst),
    .cmd (u_cmd),
    .a   (u_a),
    .b   (u_b),
    .rsp (u_rsp)
  );

  // ---- combinational helpers ----
  logic signed [39:0] sum_new;
  logic [16:0]        seen_new;
  logic [15:0]        cnt_eff;
  logic [15:0]        sens_eff;
  logic signed [39:0] sum_sh;
  logic [39:0]        sum_mag;
  logic signed [40:0] num;
  logic [40:0]        num_mag;
  logic signed [32:0] err_full;
  logic signed [31:0] err_sat;
  logic [31:0]        err_mag;
  logic signed [32:0] diff;
  logic [32:0]        diff_mag;
  logic [55:0]        q;
  logic signed [31:0] rate_sat;
  logic [31:0]        rate_mag;
  logic signed [33:0] hstep;
  logic signed [33:0] hsum;
  logic signed [32:0] istep;
  logic signed [48:0] isum;
  logic signed [47:0] int_new;
  logic signed [55:0] dq;
  logic signed [47:0] deriv_sat;
  logic [63:0]        pmag;
  logic [50:0]        pclip;
  logic signed [52:0] term;
  logic [31:0]        gp_mag;
  logic [31:0]        gi_mag;
  logic [31:0]        gd_mag;
  logic [47:0]        int_mag;
  logic [47:0]        deriv_mag;
  logic [52:0]        tot_mag;
  logic signed [52:0] tdiv;
  logic signed [52:0] t_hi;

  always_comb begin
    sum_new  = calib_sum + 40'(raw_r);
    seen_new = calib_seen + 17'd1;
    cnt_eff  = (calib_count == 16'd0) ? 16'd1 : calib_count;
    sens_eff = (lsb_per_dps == 16'd0) ? 16'd1 : lsb_per_dps;
    sum_sh   = sum_new <<< 8;
    sum_mag  = sum_sh[39] ? 40'(-sum_sh) : 40'(sum_sh);

    num      = 41'($signed({raw_r, 8'd0})) - 41'(rate_offset);
    num_mag  = num[40] ? 41'(-num) : 41'(num);

    err_full = 33'(tgt_r) - 33'(heading_acc);
    if (err_full > 33'(SAT32_MAX)) begin
      err_sat = 32'h7FFF_FFFF;
    end else if (err_full < 33'(SAT32_MIN)) begin
      err_sat = 32'h8000_0000;
    end else begin
      err_sat = err_full[31:0];
    end
    err_mag  = err_sat[31] ? 32'(-err_sat) : 32'(err_sat);

    diff     = 33'(err_r) - 33'(last_error);
    diff_mag = diff[32] ? 33'(-diff) : 33'(diff);

    q = u_rsp.res[55:0];

    // rate saturation
    if (neg_r) begin
      rate_sat = (q > 56'h8000_0000) ? 32'h8000_0000 : 32'(-q[31:0]);
    end else begin
      rate_sat = (q > 56'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
    end
    rate_mag = rate_r[31] ? 32'(-rate_r) : 32'(rate_r);

    hstep = neg_r ? -34'(q[32:0]) : 34'(q[32:0]);
    hsum  = 34'(heading_acc) + hstep;

    istep = neg_r ? -33'(q[31:0]) : 33'(q[31:0]);
    isum  = 49'(error_integral) + 49'(istep);
    if (isum > SAT48_MAX) begin
      int_new = 48'h7FFF_FFFF_FFFF;
    end else if (isum < SAT48_MIN) begin
      int_new = 48'h8000_0000_0000;
    end else begin
      int_new = isum[47:0];
    end

    dq = neg_r ? -$signed(q) : $signed(q);
    if (dq > 56'(SAT48_MAX)) begin
      deriv_sat = 48'h7FFF_FFFF_FFFF;
    end else if (dq < 56'(SAT48_MIN)) begin
      deriv_sat = 48'h8000_0000_0000;
    end else begin
      deriv_sat = dq[47:0];
    end

    pmag  = u_rsp.res[79:16];
    pclip = (pmag > TERM_LIM) ? TERM_LIM[50:0] : pmag[50:0];
    term  = neg_r ? -53'(pclip) : 53'(pclip);

    gp_mag    = gain_p[31] ? 32'(-gain_p) : 32'(gain_p);
    gi_mag    = gain_i[31] ? 32'(-gain_i) : 32'(gain_i);
    gd_mag    = gain_d[31] ? 32'(-gain_d) : 32'(gain_d);
    int_mag   = error_integral[47] ? 48'(-error_integral) : 48'(error_integral);
    deriv_mag = deriv_r[47] ? 48'(-deriv_r) : 48'(deriv_r);

    tot_mag = total_r[52] ? 53'(-total_r) : 53'(total_r);
    tdiv    = total_r[52] ? -53'(tot_mag >> 8) : 53'(tot_mag >> 8);
    t_hi    = (tdiv > $signed({37'd0, drive_max})) ? $signed({37'd0, drive_max}) : tdiv;
  end

  // ---- configuration ----
  always_ff @(posedge clk) begin
    if (rst) begin
      lsb_per_dps <= 16'd33536;
      calib_count <= 16'd1000;
      gain_p      <= '0;
      gain_i      <= '0;
      gain_d      <= '0;
      drive_min   <= 16'd8960;
      drive_max   <= 16'd20480;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LSB_PER_DPS: lsb_per_dps <= cfg_data[15:0];
        REG_CALIB_COUNT: calib_count <= cfg_data[15:0];
        REG_GAIN_P:      gain_p      <= cfg_data;
        REG_GAIN_I:      gain_i      <= cfg_data;
        REG_GAIN_D:      gain_d      <= cfg_data;
        REG_DRIVE_MIN:   drive_min   <= cfg_data[15:0];
        REG_DRIVE_MAX:   drive_max   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state != ST_IDLE);

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      u_cmd          <= '0;
      out_valid      <= 1'b0;
      heading_acc    <= '0;
      rate_offset    <= '0;
      calib_sum      <= '0;
      calib_seen     <= '0;
      error_integral <= '0;
      last_error     <= '0;
      offset_ready   <= 1'b0;
    end else begin
      u_cmd.go <= 1'b0;
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            kind_r  <= kind;
            raw_r   <= raw_rate;
            dt_r    <= time_step_us;
            tgt_r   <= target_angle;
            rate_r  <= '0;
            drive_r <= '0;
            deriv_r <= '0;
            state   <= ST_PREP;
          end
        end
        ST_PREP: begin
          case (kind_r)
            KIND_CAL: begin
              if (seen_new >= {1'b0, cnt_eff}) begin
                calib_sum  <= '0;
                calib_seen <= '0;
                neg_r      <= sum_sh[39];
                u_a        <= {16'd0, sum_mag};
                u_b        <= {16'd0, cnt_eff};
                u_cmd      <= '{go: 1'b1, op: OP_DIV};
                state      <= ST_CAL_DIV;
              end else begin
                calib_sum  <= sum_new;
                calib_seen <= seen_new;
                state      <= ST_DONE;
              end
            end
            KIND_ANGLE: begin
              neg_r <= num[40];
              u_a   <= {num_mag[39:0], 16'd0};
              u_b   <= {16'd0, sens_eff};
              u_cmd <= '{go: 1'b1, op: OP_DIV};
              state <= ST_RATE_DIV;
            end
            KIND_PID: begin
              err_r <= err_sat;
              neg_r <= err_sat[31];
              u_a   <= {24'd0, err_mag};
              u_b   <= {12'd0, dt_r};
              u_cmd <= '{go: 1'b1, op: OP_MUL};
              state <= ST_I_MUL;
            end
            default: state <= ST_DONE;
          endcase
        end
        ST_CAL_DIV: begin
          if (u_rsp.done) begin
            rate_offset  <= neg_r ? -$signed(q[39:0]) : $signed(q[39:0]);
            offset_ready <= 1'b1;
            state        <= ST_DONE;
          end
        end
        ST_RATE_DIV: begin
          if (u_rsp.done) begin
            rate_r <= rate_sat;
            state  <= ST_HEAD_MUL;
          end
        end
        ST_HEAD_MUL: begin
          // launched in the cycle after the rate lands, from the stored rate
          neg_r <= rate_r[31];
          u_a   <= {24'd0, rate_mag};
          u_b   <= {12'd0, dt_r};
          u_cmd <= '{go: 1'b1, op: OP_MUL};
          state <= ST_HEAD_DIV;
        end
        ST_HEAD_DIV: begin
          if (u_rsp.done) begin
            u_a   <= u_rsp.res[55:0];
            u_b   <= {12'd0, US_PER_S};
            u_cmd <= '{go: 1'b1, op: OP_DIV};
            state <= ST_HEAD_SUM;
          end
        end
        ST_HEAD_SUM: begin
          if (u_rsp.done) begin
            if (hsum > SAT32_MAX) begin
              heading_acc <= 32'h7FFF_FFFF;
            end else if (hsum < SAT32_MIN) begin
              heading_acc <= 32'h8000_0000;
            end else begin
              heading_acc <= hsum[31:0];
            end
            state <= ST_DONE;
          end
        end
        ST_I_MUL: begin
          if (u_rsp.done) begin
            u_a   <= u_rsp.res[55:0];
            u_b   <= {12'd0, US_PER_S};
            u_cmd <= '{go: 1'b1, op: OP_DIV};
            state <= ST_I_DIV;
          end
        end
        ST_I_DIV: begin
          if (u_rsp.done) begin
            error_integral <= int_new;
            last_error     <= err_r;
            if (dt_r != 20'd0) begin
              neg_r <= diff[32];
              u_a   <= {23'd0, diff_mag};
              u_b   <= {12'd0, US_PER_S};
              u_cmd <= '{go: 1'b1, op: OP_MUL};
              state <= ST_D_MUL;
            end else begin
              neg_r <= err_r[31] ^ gain_p[31];
              u_a   <= {24'd0, err_mag_r(err_r)};
              u_b   <= gp_mag;
              u_cmd <= '{go: 1'b1, op: OP_MUL};
              state <= ST_P_GAIN;
            end
          end
        end
        ST_D_MUL: begin
          if (u_rsp.done) begin
            u_a   <= u_rsp.res[55:0];
            u_b   <= {12'd0, dt_r};
            u_cmd <= '{go: 1'b1, op: OP_DIV};
            state <= ST_D_DIV;
          end
        end
        ST_D_DIV: begin
          if (u_rsp.done) begin
            deriv_r <= deriv_sat;
            neg_r   <= err_r[31] ^ gain_p[31];
            u_a     <= {24'd0, err_mag_r(err_r)};
            u_b     <= gp_mag;
            u_cmd   <= '{go: 1'b1, op: OP_MUL};
            state   <= ST_P_GAIN;
          end
        end
        ST_P_GAIN: begin
          if (u_rsp.done) begin
            total_r <= term;
            neg_r   <= error_integral[47] ^ gain_i[31];
            u_a     <= {8'd0, int_mag};
            u_b     <= gi_mag;
            u_cmd   <= '{go: 1'b1, op: OP_MUL};
            state   <= ST_I_GAIN;
          end
        end
        ST_I_GAIN: begin
          if (u_rsp.done) begin
            total_r <= total_r + term;
            neg_r   <= deriv_r[47] ^ gain_d[31];
            u_a     <= {8'd0, deriv_mag};
            u_b     <= gd_mag;
            u_cmd   <= '{go: 1'b1, op: OP_MUL};
            state   <= ST_D_GAIN;
          end
        end
        ST_D_GAIN: begin
          if (u_rsp.done) begin
            total_r <= total_r + term;
            state   <= ST_DRIVE;
          end
        end
        ST_DRIVE: begin
          // upper clamp first, lower clamp wins when min is above max
          drive_r <= (t_hi < $signed({37'd0, drive_min})) ? drive_min : t_hi[15:0];
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid  <= 1'b1;
            heading    <= heading_acc;
            rate_dps   <= rate_r;
            drive      <= drive_r;
            calibrated <= offset_ready;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* tb/gyro_heading_pid_controller_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gyro_heading_pid_controller_unit_tb
// Drives calibration, angle, PID and unknown-kind items with random idle gaps
// on both channels. A bit-accurate predictor computes the expected heading, rate,
// drive and ready flag for each accepted item, and a scoreboard compares them
// in order with the results that come out.
// ----------------------------------------------------------------------------
module gyro_heading_pid_controller_unit_tb;
  import ghpid_pkg::*;

  localparam longint HDG_MAX = 64'sd2147483647;
  localparam longint HDG_MIN = -64'sd2147483648;
  localparam longint INT_MAX = 64'sd140737488355327;
  localparam longint INT_MIN = -64'sd140737488355328;
  localparam longint TERM_LIM = 64'sd1125899906842624;
  localparam longint USEC = 64'sd1000000;
  localparam int IDLE_LIMIT = 20000;
  localparam logic [1:0] KIND_NONE = 2'd3;

  typedef struct {
    logic [31:0] heading;
    logic [31:0] rate_dps;
    logic [15:0] drive;
    logic        calibrated;
  } gyro_result_t;

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // (a*b)/65536 toward zero, magnitude limited to 2^50
  function automatic longint gain_mul(longint a, longint b);
    logic    neg;
    longint  ua, ub, mag;
    neg = (a < 0) != (b < 0);
    ua  = a < 0 ? -a : a;
    ub  = b < 0 ? -b : b;
    mag = (ua >>> 16) * ub + (((ua & 64'hFFFF) * ub) >>> 16);
    if (mag > TERM_LIM) mag = TERM_LIM;
    return neg ? -mag : mag;
  endfunction

  class heading_scoreboard;
    logic [15:0] lsb_per_dps, calib_count, drive_min, drive_max;
    logic [31:0] gain_p, gain_i, gain_d;
    longint heading_acc, rate_offset, calib_sum, error_integral, last_error;
    int     calib_seen;
    logic   offset_ready;
    gyro_result_t pending[$];
    int     errors;

    function void clear();
      lsb_per_dps = 16'd33536; calib_count = 16'd1000;
      gain_p = '0; gain_i = '0; gain_d = '0;
      drive_min = 16'd8960; drive_max = 16'd20480;
      heading_acc = 0; rate_offset = 0; calib_sum = 0; calib_seen = 0;
      error_integral = 0; last_error = 0; offset_ready = 0;
      pending = {}; errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_LSB_PER_DPS: lsb_per_dps = val[15:0];
        REG_CALIB_COUNT: calib_count = val[15:0];
        REG_GAIN_P:      gain_p = val;
        REG_GAIN_I:      gain_i = val;
        REG_GAIN_D:      gain_d = val;
        REG_DRIVE_MIN:   drive_min = val[15:0];
        REG_DRIVE_MAX:   drive_max = val[15:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [1:0] k, logic signed [15:0] raw, logic [19:0] dt_in,
                            logic signed [31:0] target);
      longint raw_l, dt, cnt, sens, rate, err, deriv, total;
      gyro_result_t r;
      raw_l = raw; dt = dt_in; rate = 0; total = 0; r.drive = '0;
      case (k)
        KIND_CAL: begin
          cnt = calib_count == 0 ? 1 : calib_count;
          calib_sum += raw_l;
          calib_seen++;
          if (calib_seen >= cnt) begin
            rate_offset = (calib_sum * 256) / cnt;
            offset_ready = 1;
            calib_sum = 0;
            calib_seen = 0;
          end
        end
        KIND_ANGLE: begin
          sens = lsb_per_dps == 0 ? 1 : lsb_per_dps;
          rate = clip(((raw_l * 256 - rate_offset) * 65536) / sens, HDG_MIN, HDG_MAX);
          heading_acc = clip(heading_acc + (rate * dt) / USEC, HDG_MIN, HDG_MAX);
        end
        KIND_PID: begin
          err = clip(longint'(target) - heading_acc, HDG_MIN, HDG_MAX);
          error_integral = clip(error_integral + (err * dt) / USEC, INT_MIN, INT_MAX);
          deriv = dt != 0 ? clip(((err - last_error) * USEC) / dt, INT_MIN, INT_MAX) : 0;
          last_error = err;
          total = gain_mul(err, longint'(signed'(gain_p)))
                + gain_mul(error_integral, longint'(signed'(gain_i)))
                + gain_mul(deriv, longint'(signed'(gain_d)));
          total /= 256;
          if (total > longint'(drive_max)) total = drive_max;
          if (total < longint'(drive_min)) total = drive_min;
          r.drive = total[15:0];
        end
        default: ;
      endcase
      r.heading = heading_acc[31:0];
      r.rate_dps = rate[31:0];
      r.calibrated = offset_ready;
      pending.push_back(r);
    endfunction

    function void check_result(logic [31:0] hd, logic [31:0] rt, logic [15:0] dr, logic cb);
      gyro_result_t e;
      if (pending.size() == 0) begin
        $error("result with nothing expected: heading %h", hd);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (hd !== e.heading) begin
        $error("heading exp %h got %h", e.heading, hd); errors++;
      end
      if (rt !== e.rate_dps) begin
        $error("rate_dps exp %h got %h", e.rate_dps, rt); errors++;
      end
      if (dr !== e.drive) begin
        $error("drive exp %h got %h", e.drive, dr); errors++;
      end
      if (cb !== e.calibrated) begin
        $error("calibrated exp %b got %b", e.calibrated, cb); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic in_valid = 0, in_stall;
  logic [1:0] kind = '0;
  logic signed [15:0] raw_rate = '0;
  logic [19:0] time_step_us = '0;
  logic signed [31:0] target_angle = '0;
  logic out_valid, out_stall = 0;
  logic signed [31:0] heading, rate_dps;
  logic [15:0] drive;
  logic calibrated;

  heading_scoreboard sb;
  int idle_cycles = 0;
  bit sink_on = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  gyro_heading_pid_controller_unit u_dut (.*);

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side with random stalls
  initial begin
    int gap;
    wait (sink_on);
    forever begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      if (gap > 0) begin
        out_stall <= 1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_result(heading, rate_dps, drive, calibrated);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  task automatic send_item(logic [1:0] k, logic [15:0] raw, logic [19:0] dt,
                           logic [31:0] target, bit gaps);
    int gap;
    gap = gaps ? ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18)) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1; kind <= k; raw_rate <= raw; time_step_us <= dt; target_angle <= target;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(k, raw, dt, target);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [19:0] rand_dt();
    case ($urandom_range(0, 5))
      0: return 20'd0;
      1: return 20'd1000000;
      2: return 20'hFFFFF;
      default: return 20'($urandom_range(1, 5000));
    endcase
  endfunction

  function automatic logic [15:0] rand_raw();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
    endcase
  endfunction

  initial begin
    int n, ph;
    logic [31:0] tgt;
    sb = new();
    sb.clear();
    repeat (4) @(posedge clk);
    rst <= 0;
    sink_on = 1;
    // directed: defaults, then small count with extreme fields
    send_item(KIND_ANGLE, 16'h7FFF, 20'd1000, 32'd0, 0);
    send_item(KIND_PID, 16'd0, 20'd1000, 32'h0100_0000, 0);
    send_item(KIND_NONE, 16'hFFFF, 20'hFFFFF, 32'hFFFF_FFFF, 0);
    drain();
    write_reg(REG_CALIB_COUNT, 32'd3);
    write_reg(REG_GAIN_P, 32'h0001_0000);
    write_reg(REG_GAIN_I, 32'h0000_8000);
    write_reg(REG_GAIN_D, 32'h0000_0100);
    send_item(KIND_CAL, 16'h8000, 20'd0, 32'd0, 0);
    send_item(KIND_CAL, 16'h7FFF, 20'd0, 32'd0, 0);
    send_item(KIND_CAL, 16'd5, 20'd0, 32'd0, 0);
    send_item(KIND_ANGLE, 16'h8000, 20'hFFFFF, 32'd0, 0);
    send_item(KIND_ANGLE, 16'h7FFF, 20'd1000000, 32'd0, 0);
    send_item(KIND_PID, 16'd0, 20'd0, 32'h8000_0000, 0);
    send_item(KIND_PID, 16'd0, 20'hFFFFF, 32'h7FFF_FFFF, 0);
    send_item(KIND_CAL, 16'd7, 20'd0, 32'd0, 0);
    drain();
    // count lowered mid-calibration, zero sensitivity and count, min above max
    write_reg(REG_CALIB_COUNT, 32'd0);
    write_reg(REG_LSB_PER_DPS, 32'd0);
    write_reg(REG_DRIVE_MIN, 32'hFFFF);
    write_reg(REG_DRIVE_MAX, 32'd0);
    send_item(KIND_CAL, 16'd9, 20'd0, 32'd0, 0);
    send_item(KIND_ANGLE, 16'd3, 20'd10, 32'd0, 0);
    send_item(KIND_PID, 16'd0, 20'd50, 32'h0003_0000, 0);
    send_item(KIND_NONE, 16'd0, 20'd0, 32'd0, 0);
    drain();

    n = 0;
    for (ph = 0; ph < 10; ph++) begin
      write_reg(REG_LSB_PER_DPS, ph == 1 ? 32'hFFFF : ph == 2 ? 32'd1 : $urandom_range(1, 65535));
      write_reg(REG_CALIB_COUNT, ph == 3 ? 32'hFFFF : $urandom_range(1, 8));
      write_reg(REG_GAIN_P, rand_gain());
      write_reg(REG_GAIN_I, rand_gain());
      write_reg(REG_GAIN_D, rand_gain());
      write_reg(REG_DRIVE_MIN, ph == 4 ? 32'd0 : $urandom_range(0, 20000));
      write_reg(REG_DRIVE_MAX, ph == 4 ? 32'hFFFF : $urandom_range(10000, 65535));
      repeat (175) begin
        case ($urandom_range(0, 9))
          0, 1, 2: send_item(KIND_CAL, rand_raw(), rand_dt(), $urandom, ph % 3 != 0);
          3, 4, 5: send_item(KIND_ANGLE, rand_raw(), rand_dt(), $urandom, ph % 3 != 0);
          9: send_item(KIND_NONE, 16'($urandom), 20'($urandom), $urandom, ph % 3 != 0);
          default: begin
            tgt = $urandom_range(0, 3) == 0 ? $urandom
                : sb.heading_acc[31:0] + 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
            send_item(KIND_PID, 16'($urandom), rand_dt(), tgt, ph % 3 != 0);
          end
        endcase
        n++;
        // pause until all results are in
        if (n == 600) begin
          in_valid <= 0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      drain();
    end
    if (sb.errors == 0 && sb.pending.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

/* sim.f */
rtl/ghpid_pkg.sv
rtl/ghpid_serial.sv
rtl/gyro_heading_pid_controller_unit.sv
tb/gyro_heading_pid_controller_unit_tb.sv
